// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, operation codes and status codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    typedef logic [2:0]               func_t;
    typedef logic [1:0]               status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam func_t FN_INS_FRONT = 3'd0;
    localparam func_t FN_INS_REAR  = 3'd1;
    localparam func_t FN_DEL_FRONT = 3'd2;
    localparam func_t FN_DEL_REAR  = 3'd3;
    localparam func_t FN_LIST      = 3'd4;
    localparam func_t FN_CLEAR     = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    push_front;
        logic    push_rear;
        logic    pop_front;
        logic    pop_rear;
        logic    clear;
        logic    list_rd;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        logic    out_from_ram;
        logic    out_last_idx;
        status_t out_status;
    } bdq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_last;
        logic out_free;
    } bdq_stat_t;

endpackage

// ===== rtl/core/bdq_req_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if;
    logic            valid;
    logic            ready;
    bdq_pkg::func_t  func;
    bdq_pkg::data_t  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/core/bdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface bdq_rsp_if #(
    parameter int OCC_W = $clog2(bdq_pkg::DEPTH_DEF + 1)
);
    logic              valid;
    logic              ready;
    bdq_pkg::status_t  status;
    bdq_pkg::data_t    data;
    logic              last;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output data, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data, input last,
                    input occupancy, output ready);
endinterface

// ===== rtl/core/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring pointers, item store, list index and the result output register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bdq_pkg::bdq_cmd_t  cmd,
    output bdq_pkg::bdq_stat_t stat,
    input  bdq_pkg::data_t     value,
    output logic               out_valid,
    input  logic               out_ready,
    output bdq_pkg::status_t   out_status,
    output bdq_pkg::data_t     out_data,
    output logic               out_last,
    output logic [CW-1:0]      out_occ
);
    import bdq_pkg::*;

    localparam int             AW       = $clog2(DEPTH);
    localparam logic [AW:0]    DEPTH_S  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]  LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg;
    data_t         out_data_reg;
    logic          out_last_reg;
    logic [CW-1:0] out_occ_reg;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] rear_free;
    logic [AW-1:0] rear_item;
    logic [AW-1:0] list_pos;
    logic          we;
    logic [AW-1:0] waddr;
    logic          re;
    logic [AW-1:0] raddr;
    data_t         rdata;

    // fold a sum below twice the depth back into the ring
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_S) ? s - DEPTH_S : s;
        return t[AW-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - AW'(1);
    assign front_inc = wrap({1'b0, front_reg} + (AW + 1)'(1));
    assign rear_free = wrap({1'b0, front_reg} + (AW + 1)'(count_reg));
    assign rear_item = wrap({1'b0, front_reg} + (AW + 1)'(count_reg) - (AW + 1)'(1));
    assign list_pos  = wrap({1'b0, front_reg} + {1'b0, idx_reg});

    assign we    = cmd.push_front | cmd.push_rear;
    assign waddr = cmd.push_front ? front_dec : rear_free;
    assign re    = cmd.pop_front | cmd.pop_rear | cmd.list_rd;
    always_comb
    begin
        if (cmd.pop_front)
        begin
            raddr = front_reg;
        end
        else if (cmd.pop_rear)
        begin
            raddr = rear_item;
        end
        else
        begin
            raddr = list_pos;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            front_next = '0;
            count_next = '0;
        end
        else if (cmd.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.push_rear)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            front_next = front_inc;
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_rear)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the result word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_from_ram ? rdata : '0;
            out_last_reg   <= cmd.out_last_idx ? stat.idx_last : 1'b1;
            out_occ_reg    <= count_next;
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == FULL_CNT);
    assign stat.idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;
    assign out_occ    = out_occ_reg;
endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Operation sequencer: decodes each request and steps reads and list walks.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bdq_pkg::func_t     func,
    input  bdq_pkg::bdq_stat_t stat,
    output bdq_pkg::bdq_cmd_t  cmd
);
    import bdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LRD  = 2'd2;
    localparam logic [1:0] S_LWT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_INS_FRONT:
                        begin
                            cmd.out_load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_front = 1'b1;
                            end
                        end
                        FN_INS_REAR:
                        begin
                            cmd.out_load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_rear = 1'b1;
                            end
                        end
                        FN_DEL_FRONT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_front = 1'b1;
                                state_next    = S_POP;
                            end
                        end
                        FN_DEL_REAR:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_rear = 1'b1;
                                state_next   = S_POP;
                            end
                        end
                        FN_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = S_LRD;
                            end
                        end
                        FN_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // wait for a free output slot, then hand over the read data
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_LRD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = S_LWT;
            end
            S_LWT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    cmd.out_last_idx = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_LRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/core/bounded_deque.sv =====
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Result: insert, clear, empty delete and empty list give their result word
//   at the edge after acceptance; a delete waits on the registered RAM read.
// Throughput: one word per cycle for inserts while the output is free; deletes
//   and lists stall the request side; a list reads then outputs each stored word.
// Reset: ring pointers, count, sequencer and output valid clear at once;
//   the item store is not cleared, only written entries are ever read.
module bounded_deque #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bdq_req_if.sink     req,
    bdq_rsp_if.source   rsp
);
    import bdq_pkg::*;

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .func     (req.func),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .value      (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_data   (rsp.data),
        .out_last   (rsp.last),
        .out_occ    (rsp.occupancy)
    );
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_deque: drives front/rear inserts and
// deletes, lists, clears and spare codes through the request channel.
// A scoreboard keeps its own ring model, predicts every response word and
// compares it field by field. The sender idles in bursts and the receiver
// stalls on its own pattern, including one long hold that backs up the block.
// ----------------------------------------------------------------------------
module tb_top;
    import bdq_pkg::*;

    localparam int    DEPTH        = DEPTH_DEF;
    localparam int    OCC_W        = $clog2(DEPTH + 1);
    localparam int    CLK_PERIOD   = 12;
    localparam int    RESET_CYCLES = 6;
    localparam int    RANDOM_OPS   = 60;
    localparam int    LONG_HOLD    = 150;
    localparam int    STALL_LIMIT  = 2000;
    localparam int    DRAIN_CYCLES = 20;
    localparam func_t FN_SPARE_6   = 3'd6;
    localparam func_t FN_SPARE_7   = 3'd7;

    typedef logic [OCC_W-1:0] occ_t;

    typedef struct packed {
        status_t status;
        data_t   data;
        logic    last;
        occ_t    occupancy;
    } deque_word_t;

    class deque_scoreboard;
        data_t       ring [DEPTH];
        int          head;
        int          count;
        deque_word_t expected_q [$];
        int          errors;

        function new();
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function void push_word(status_t st, data_t d, logic l);
            deque_word_t w;
            w.status    = st;
            w.data      = d;
            w.last      = l;
            w.occupancy = occ_t'(count);
            expected_q.push_back(w);
        endfunction

        function void note_request(func_t f, data_t v);
            case (f)
                FN_INS_FRONT:
                begin
                    if (count == DEPTH)
                    begin
                        push_word(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = v;
                        count++;
                        push_word(ST_OK, '0, 1'b1);
                    end
                end
                FN_INS_REAR:
                begin
                    if (count == DEPTH)
                    begin
                        push_word(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        ring[(head + count) % DEPTH] = v;
                        count++;
                        push_word(ST_OK, '0, 1'b1);
                    end
                end
                FN_DEL_FRONT:
                begin
                    if (count == 0)
                    begin
                        push_word(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        count--;
                        head = (head + 1) % DEPTH;
                        push_word(ST_OK, ring[(head + DEPTH - 1) % DEPTH], 1'b1);
                    end
                end
                FN_DEL_REAR:
                begin
                    if (count == 0)
                    begin
                        push_word(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        count--;
                        push_word(ST_OK, ring[(head + count) % DEPTH], 1'b1);
                    end
                end
                FN_LIST:
                begin
                    if (count == 0)
                    begin
                        push_word(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < count; i++)
                        begin
                            push_word(ST_OK, ring[(head + i) % DEPTH], i == count - 1);
                        end
                    end
                end
                FN_CLEAR:
                begin
                    head  = 0;
                    count = 0;
                    push_word(ST_OK, '0, 1'b1);
                end
                default:
                begin
                    // spare codes leave the store alone
                    push_word(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_word(deque_word_t got);
            deque_word_t want;
            if (expected_q.size() == 0)
            begin
                $error("response word with nothing expected: status %0d data %0d",
                       got.status, $signed(got.data));
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.data !== want.data)
            begin
                $error("data: expected %0d, got %0d", $signed(want.data), $signed(got.data));
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_req   = 1'b0;
    int   burst_left = 4;

    deque_scoreboard sb = new();

    bdq_req_if                    req_ch ();
    bdq_rsp_if #(.OCC_W(OCC_W))   rsp_ch ();

    bounded_deque #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one word and hold it until taken; idle between bursts.
    task automatic send_word(func_t f, data_t v);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(f, v);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic data_t rand_value();
        case ($urandom_range(0, 9))
            0:       return data_t'(32'h7FFF_FFFF);
            1:       return data_t'(32'h8000_0000);
            2:       return '0;
            default: return data_t'($urandom);
        endcase
    endfunction

    // Receiver: switch at random among four stall patterns
    initial
    begin
        int   mode;
        int   mode_left;
        int   stall_left;
        int   phase;
        logic rdy;
        rsp_ch.ready = 1'b0;
        mode         = 0;
        mode_left    = 0;
        stall_left   = 0;
        phase        = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req     <= 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (phase % 3) != 0;
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 8);
                    end
                end
            endcase
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        deque_word_t got;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.status    = rsp_ch.status;
            got.data      = rsp_ch.data;
            got.last      = rsp_ch.last;
            got.occupancy = rsp_ch.occupancy;
            sb.check_word(got);
        end
    end

    // Abort when neither channel moves a word for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int    r;
        int    ins_pct;
        int    mode_left;
        func_t f;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FN_INS_FRONT;
        req_ch.value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cases, extremes, every code
        send_word(FN_DEL_FRONT, rand_value());
        send_word(FN_DEL_REAR, rand_value());
        send_word(FN_LIST, rand_value());
        send_word(FN_INS_FRONT, data_t'(32'h7FFF_FFFF));
        send_word(FN_INS_REAR, data_t'(32'h8000_0000));
        send_word(FN_INS_FRONT, '0);
        send_word(FN_INS_REAR, data_t'(32'hFFFF_FFFF));
        send_word(FN_LIST, rand_value());
        send_word(FN_DEL_FRONT, rand_value());
        send_word(FN_DEL_REAR, rand_value());
        send_word(FN_SPARE_6, data_t'($urandom));
        send_word(FN_SPARE_7, data_t'($urandom));
        send_word(FN_LIST, rand_value());
        send_word(FN_CLEAR, rand_value());
        send_word(FN_LIST, rand_value());
        send_word(FN_DEL_REAR, rand_value());

        // hold the receiver while the store fills, overflows and lists
        hold_req <= 1'b1;
        send_word(FN_CLEAR, rand_value());
        for (int i = 0; i < DEPTH; i++)
        begin
            send_word((i % 2) ? FN_INS_REAR : FN_INS_FRONT, rand_value());
        end
        send_word(FN_INS_FRONT, rand_value());
        send_word(FN_INS_REAR, rand_value());
        send_word(FN_LIST, rand_value());
        send_word(FN_DEL_FRONT, rand_value());
        send_word(FN_DEL_REAR, rand_value());
        send_word(FN_LIST, rand_value());

        // random walk, biased toward filling, draining or neither in turn
        ins_pct   = 45;
        mode_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 70;
                    1:       ins_pct = 20;
                    default: ins_pct = 45;
                endcase
                mode_left = $urandom_range(12, 24);
            end
            mode_left--;
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                f = $urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT;
            else if (r < 88)
                f = $urandom_range(0, 1) ? FN_DEL_REAR : FN_DEL_FRONT;
            else if (r < 95)
                f = FN_LIST;
            else if (r < 97)
                f = FN_CLEAR;
            else
                f = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
            send_word(f, rand_value());
        end

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_req_if.sv
rtl/core/bdq_rsp_if.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_datapath.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque.sv
test/tb_top.sv
